FILE: sv/assert_macros.svh
// Assertion macros used by the RTL queue module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/oqpi_pkg.sv
// Shared types and constants of the ordered queue with positional insert.
`default_nettype none
package oqpi_pkg;

  // Queue depth; a power of two so that ring pointers wrap by truncation.
  localparam int DEPTH   = 32;
  localparam int ID_BITS = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_INS_POS   = 2'd2,
    OP_REMOVE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_FRONT_RD,
    S_FRONT_WAIT
  } state_t;

  typedef struct packed {
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ID_BITS-1:0] wdata;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: sv/oqpi_ram.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module oqpi_ram (
  input  wire                          clk,
  input  oqpi_pkg::ram_req_t           req,
  output logic [oqpi_pkg::ID_BITS-1:0] rd_data
);
  import oqpi_pkg::*;

  logic [ID_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/ordered_queue_positional_insert.sv
// A remove or rejected request passes S_FRONT_RD and S_FRONT_WAIT before out_tvalid rises;
// an insert that shifts k entries back first runs k shift read/write pairs and S_WRITE.
// Requests are taken only in S_IDLE, once the last result is loaded (it waits on out_tready);
// the shift loop moves one entry per read/write pair through the shared ring-address adder.
// Front and back inserts need no shift; insert at 1-based slot p>1 shifts count-p+1 entries.
// Reset (rst_n low, synchronous) empties the queue; the entry store itself is not cleared.
`default_nettype none
module ordered_queue_positional_insert (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // [1:0] operation, [17:2] patient_id, [23:18] position
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [7:2] entry_count, [23:8] front_id,
                                  // [24] front_valid, [31:25] zero
);
  import oqpi_pkg::*;
  `include "assert_macros.svh"

  // Sequencer and queue state.
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  head_r, head_nxt;     // ring slot of the front entry
  logic [CNT_W-1:0]   count_r, count_nxt;   // entries held
  logic [CNT_W-1:0]   slot_r, slot_nxt;     // logical insert slot, 0 is the front
  logic [CNT_W-1:0]   idx_r, idx_nxt;       // logical slot being filled by the shift loop
  logic [ID_BITS-1:0] id_r, id_nxt;
  status_t            st_r, st_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  status_t            out_st_r, out_st_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [ID_BITS-1:0] out_front_r, out_front_nxt;
  logic               out_fvalid_r, out_fvalid_nxt;

  // Shared ring-address adder and entry store.
  logic [ADDR_W-1:0]  offs;
  logic [ADDR_W-1:0]  addr;
  ram_req_t           ram_req;
  logic [ID_BITS-1:0] ram_rdata;

  // Request fields.
  op_t                in_op;
  logic [ID_BITS-1:0] in_id;
  logic [5:0]         in_pos;

  assign in_op  = op_t'(in_tdata[1:0]);
  assign in_id  = in_tdata[17:2];
  assign in_pos = in_tdata[23:18];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fvalid_r, out_front_r, 6'(out_cnt_r), out_st_r};

  oqpi_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  // Pick the logical offset for this cycle, then map it onto the ring.
  always_comb begin
    unique case (state_r)
      S_SHIFT_RD: offs = ADDR_W'(idx_r - CNT_W'(1));
      S_SHIFT_WR: offs = ADDR_W'(idx_r);
      S_WRITE:    offs = ADDR_W'(slot_r);
      default:    offs = '0;
    endcase
    addr = head_r + offs;
  end

  always_comb begin
    logic             ins;
    logic [CNT_W-1:0] ins_slot;

    ins            = 1'b0;
    ins_slot       = '0;
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    id_nxt         = id_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_st_nxt     = out_st_r;
    out_cnt_nxt    = out_cnt_r;
    out_front_nxt  = out_front_r;
    out_fvalid_nxt = out_fvalid_r;
    ram_req        = '0;
    ram_req.raddr  = addr;
    ram_req.waddr  = addr;

    // Drop the result once the sink takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          id_nxt    = in_id;
          st_nxt    = ST_DONE;
          state_nxt = S_FRONT_RD;
          case (in_op)
            OP_REMOVE: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                head_nxt  = head_r + ADDR_W'(1);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_INS_POS: begin
              if (in_pos == '0 || 7'(in_pos) > 7'(count_r) + 7'd1) begin
                st_nxt = ST_BADPOS;
              end else if (count_r == CNT_W'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                ins      = 1'b1;
                ins_slot = CNT_W'(in_pos - 6'd1);
              end
            end
            OP_INS_FRONT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                ins = 1'b1;
              end
            end
            default: begin
              if (count_r == CNT_W'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                ins      = 1'b1;
                ins_slot = count_r;
              end
            end
          endcase
          // Front insert moves the head back; a tail insert writes straight in;
          // anything else shifts the tail back one entry at a time first.
          if (ins) begin
            idx_nxt = count_r;
            if (ins_slot == '0) begin
              head_nxt  = head_r - ADDR_W'(1);
              slot_nxt  = '0;
              state_nxt = S_WRITE;
            end else if (ins_slot == count_r) begin
              slot_nxt  = ins_slot;
              state_nxt = S_WRITE;
            end else begin
              slot_nxt  = ins_slot;
              state_nxt = S_SHIFT_RD;
            end
          end
        end
      end
      S_SHIFT_RD: begin
        ram_req.re = 1'b1;
        state_nxt  = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = ram_rdata;
        idx_nxt       = idx_r - CNT_W'(1);
        if (idx_r - CNT_W'(1) == slot_r) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_WRITE: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = id_r;
        count_nxt     = count_r + CNT_W'(1);
        state_nxt     = S_FRONT_RD;
      end
      S_FRONT_RD: begin
        ram_req.re = 1'b1;
        state_nxt  = S_FRONT_WAIT;
      end
      S_FRONT_WAIT: begin
        // Hold the front read until the result register frees up.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_st_nxt     = st_r;
          out_cnt_nxt    = count_r;
          out_fvalid_nxt = (count_r != '0);
          out_front_nxt  = (count_r != '0) ? ram_rdata : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    idx_r        <= idx_nxt;
    id_r         <= id_nxt;
    st_r         <= st_nxt;
    out_st_r     <= out_st_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_front_r  <= out_front_nxt;
    out_fvalid_r <= out_fvalid_nxt;
  end

  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "entry count exceeds depth")
  `ASSERT_ALWAYS(a_full_status,
                 !out_valid_r || out_st_r != ST_FULL || out_cnt_r == CNT_W'(DEPTH),
                 "full status with room left")
  `ASSERT_ALWAYS(a_empty_status,
                 !out_valid_r || out_st_r != ST_EMPTY || out_cnt_r == '0,
                 "empty status with entries held")
  `ASSERT_ALWAYS(a_shift_range,
                 !(state_r == S_SHIFT_RD || state_r == S_SHIFT_WR) ||
                 (idx_r > slot_r && count_r < CNT_W'(DEPTH)),
                 "shift loop out of range")
  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, state_r != S_IDLE,
               "sequencer idle after accepting a request")

endmodule
`default_nettype wire
